>>> rtl/dtfe_pkg.sv
// Package for the date and time field editor: codes, limits and calendar helpers.
`timescale 1ns / 1ps

package dtfe_pkg;

   // Event codes carried in the kind field.
   localparam logic [2:0] KIND_NEXT   = 3'd0;
   localparam logic [2:0] KIND_UP     = 3'd1;
   localparam logic [2:0] KIND_DOWN   = 3'd2;
   localparam logic [2:0] KIND_UPDATE = 3'd3;
   localparam logic [2:0] KIND_SYNC   = 3'd4;

   // Selected field codes.
   localparam logic [2:0] SEL_YEAR   = 3'd0;
   localparam logic [2:0] SEL_MONTH  = 3'd1;
   localparam logic [2:0] SEL_DAY    = 3'd2;
   localparam logic [2:0] SEL_HOUR   = 3'd3;
   localparam logic [2:0] SEL_MINUTE = 3'd4;
   localparam logic [2:0] SEL_SECOND = 3'd5;
   localparam logic [2:0] SEL_TOTAL  = 3'd6;

   localparam logic [11:0] YEAR_MAX   = 12'd2099;
   localparam logic [11:0] YEAR_MIN   = 12'd2000;
   localparam logic [11:0] YEAR_RESET = 12'd2026;

   localparam logic [4:0] MONTH_LEN [12] = '{
      5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
      5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
   };

   // Divisibility by 25 through the reciprocal 1311 / 2^15. For a multiple of
   // 25 below 1024 the low fraction bits stay at 7 * (q / 25), at most 287;
   // any other value leaves at least 1311 there.
   localparam logic [20:0] RECIP_25   = 21'd1311;
   localparam logic [14:0] FRAC_LIMIT = 15'd287;

   function automatic logic div_by_25(input logic [9:0] q);
      logic [20:0] prod;
      prod = {11'd0, q} * RECIP_25;
      return prod[14:0] <= FRAC_LIMIT;
   endfunction

   // Gregorian leap rule.
   function automatic logic leap_year(input logic [11:0] y);
      logic div4;
      logic div100;
      logic div400;
      div4   = y[1:0] == 2'd0;
      div100 = div4 && div_by_25(y[11:2]);
      div400 = (y[3:0] == 4'd0) && div_by_25({2'd0, y[11:4]});
      return div4 && (!div100 || div400);
   endfunction

   // Month length; months outside 1 to 12 count as 31 days.
   function automatic logic [4:0] month_days(input logic [11:0] y, input logic [3:0] m);
      logic [4:0] days;
      if (m < 4'd1 || m > 4'd12) begin
         days = 5'd31;
      end else if (m == 4'd2 && leap_year(y)) begin
         days = 5'd29;
      end else begin
         days = MONTH_LEN[m - 4'd1];
      end
      return days;
   endfunction

   // Remainder for a value known to stay below three times the modulus.
   function automatic logic [6:0] mod_reduce(input logic [6:0] t, input logic [6:0] m);
      logic [6:0] r;
      if (t >= {m[5:0], 1'b0}) begin
         r = t - {m[5:0], 1'b0};
      end else if (t >= m) begin
         r = t - m;
      end else begin
         r = t;
      end
      return r;
   endfunction

endpackage

>>> rtl/date_time_field_editor.sv
// Date and time field editor: edited calendar value, field selection and clock loading.
`timescale 1ns / 1ps
// The result word for an event appears in the cycle after the event word is taken.
// Throughput: one event word per cycle unless a waiting result is held off, set by the
// edited-value registers that feed back through the step, wrap and clamp logic.
// Reset clears the result valid flag and the loaded flag and sets the edited value to
// 2026-01-01 00:00:00 with the year field selected.

module date_time_field_editor
   import dtfe_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_kind,
   input  logic [11:0] req_in_year,
   input  logic [3:0]  req_in_month,
   input  logic [4:0]  req_in_day,
   input  logic [4:0]  req_in_hour,
   input  logic [5:0]  req_in_minute,
   input  logic [5:0]  req_in_second,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [11:0] rsp_out_year,
   output logic [3:0]  rsp_out_month,
   output logic [4:0]  rsp_out_day,
   output logic [4:0]  rsp_out_hour,
   output logic [5:0]  rsp_out_minute,
   output logic [5:0]  rsp_out_second,
   output logic [2:0]  rsp_out_field
);

   // The edited value registers double as the result register: each event word
   // leaves its new state there, and the state only moves when a word is taken.
   logic [11:0] year_ff, year_in;
   logic [3:0]  month_ff, month_in;
   logic [4:0]  day_ff, day_in;
   logic [4:0]  hour_ff, hour_in;
   logic [5:0]  minute_ff, minute_in;
   logic [5:0]  second_ff, second_in;
   logic [2:0]  field_ff, field_in;
   logic        loaded_ff, loaded_in;
   logic        rsp_valid_ff, rsp_valid_in;

   logic        accept;
   logic        up;
   logic [11:0] step_year;
   logic [3:0]  step_month;
   logic [4:0]  step_day;
   logic [4:0]  step_hour;
   logic [5:0]  step_minute;
   logic [5:0]  step_second;
   logic [4:0]  cur_days;
   logic [4:0]  new_days;
   logic [6:0]  day_sum;
   logic [6:0]  day_wrap;
   logic [6:0]  hour_wrap;
   logic [6:0]  minute_wrap;
   logic [6:0]  second_wrap;
   logic [3:0]  field_sum;

   // An event word is held off only while a finished result waits to be taken;
   // a result that leaves in this cycle makes room for the next word.
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      up = req_kind == KIND_UP;

      // Wrap arithmetic for each field works on sums that stay below three
      // times the modulus, so two compare-and-subtract steps are enough.
      cur_days    = month_days(year_ff, month_ff);
      day_sum     = up ? ({2'd0, day_ff} + {2'd0, cur_days})
                       : ({2'd0, day_ff} + {2'd0, cur_days} - 7'd2);
      day_wrap    = mod_reduce(day_sum, {2'd0, cur_days}) + 7'd1;
      hour_wrap   = mod_reduce({2'd0, hour_ff} + (up ? 7'd25 : 7'd23), 7'd24);
      minute_wrap = mod_reduce({1'b0, minute_ff} + (up ? 7'd61 : 7'd59), 7'd60);
      second_wrap = mod_reduce({1'b0, second_ff} + (up ? 7'd61 : 7'd59), 7'd60);

      step_year   = year_ff;
      step_month  = month_ff;
      step_day    = day_ff;
      step_hour   = hour_ff;
      step_minute = minute_ff;
      step_second = second_ff;

      case (field_ff)
         SEL_YEAR: begin
            // The year saturates at both ends of the century.
            if (up && year_ff < YEAR_MAX) begin
               step_year = year_ff + 12'd1;
            end else if (!up && year_ff > YEAR_MIN) begin
               step_year = year_ff - 12'd1;
            end
         end
         SEL_MONTH: begin
            // Months wrap through 1 to 12; values above 12 fold back in.
            if (up) begin
               step_month = (month_ff < 4'd12) ? month_ff + 4'd1 : month_ff - 4'd11;
            end else if (month_ff < 4'd2) begin
               step_month = month_ff + 4'd11;
            end else if (month_ff < 4'd14) begin
               step_month = month_ff - 4'd1;
            end else begin
               step_month = month_ff - 4'd13;
            end
         end
         SEL_DAY:    step_day    = day_wrap[4:0];
         SEL_HOUR:   step_hour   = hour_wrap[4:0];
         SEL_MINUTE: step_minute = minute_wrap[5:0];
         SEL_SECOND: step_second = second_wrap[5:0];
         default: begin
         end
      endcase

      // After any step the day is pulled down to the length of the month.
      new_days = month_days(step_year, step_month);
      if (step_day > new_days) begin
         step_day = new_days;
      end

      field_sum = {1'b0, field_ff} + 4'd1;

      year_in      = year_ff;
      month_in     = month_ff;
      day_in       = day_ff;
      hour_in      = hour_ff;
      minute_in    = minute_ff;
      second_in    = second_ff;
      field_in     = field_ff;
      loaded_in    = loaded_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (accept) begin
         rsp_valid_in = 1'b1;
         case (req_kind)
            KIND_NEXT: begin
               field_in = (field_sum >= {1'b0, SEL_TOTAL})
                        ? 3'(field_sum - {1'b0, SEL_TOTAL}) : field_sum[2:0];
            end
            KIND_UP, KIND_DOWN: begin
               year_in   = step_year;
               month_in  = step_month;
               day_in    = step_day;
               hour_in   = step_hour;
               minute_in = step_minute;
               second_in = step_second;
            end
            KIND_UPDATE, KIND_SYNC: begin
               // A clock update loads only until the first load; a sync always loads.
               if (req_kind == KIND_SYNC || !loaded_ff) begin
                  year_in   = req_in_year;
                  month_in  = req_in_month;
                  day_in    = req_in_day;
                  hour_in   = req_in_hour;
                  minute_in = req_in_minute;
                  second_in = req_in_second;
                  loaded_in = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         year_ff      <= YEAR_RESET;
         month_ff     <= 4'd1;
         day_ff       <= 5'd1;
         hour_ff      <= 5'd0;
         minute_ff    <= 6'd0;
         second_ff    <= 6'd0;
         field_ff     <= SEL_YEAR;
         loaded_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         year_ff      <= year_in;
         month_ff     <= month_in;
         day_ff       <= day_in;
         hour_ff      <= hour_in;
         minute_ff    <= minute_in;
         second_ff    <= second_in;
         field_ff     <= field_in;
         loaded_ff    <= loaded_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_year   = year_ff;
   assign rsp_out_month  = month_ff;
   assign rsp_out_day    = day_ff;
   assign rsp_out_hour   = hour_ff;
   assign rsp_out_minute = minute_ff;
   assign rsp_out_second = second_ff;
   assign rsp_out_field  = field_ff;

   // A forced sync always leaves the block marked as loaded.
   a_sync_loads: assert property (@(posedge clock) disable iff (reset)
      accept && req_kind == KIND_SYNC |=> loaded_ff)
      else $error("loaded flag not set after a forced sync");

   // Once loaded, the flag stays set until reset.
   a_loaded_holds: assert property (@(posedge clock) disable iff (reset)
      loaded_ff |=> loaded_ff)
      else $error("loaded flag dropped without reset");

   // Advancing the selection always lands on one of the six fields.
   a_field_range: assert property (@(posedge clock) disable iff (reset)
      accept && req_kind == KIND_NEXT |=> field_ff < SEL_TOTAL)
      else $error("field selection left the six fields");

   // A step never leaves a day beyond the length of its month.
   a_day_clamped: assert property (@(posedge clock) disable iff (reset)
      accept && (req_kind == KIND_UP || req_kind == KIND_DOWN)
      |=> day_ff <= month_days(year_ff, month_ff))
      else $error("day exceeds month length after a step");

   // No event word is taken while a waiting result is held off.
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |-> !accept)
      else $error("event word taken over a stalled result");

endmodule

>>> tb/tb_date_time_field_editor.sv
// Self-checking testbench for the date and time field editor.
`timescale 1ns / 1ps

module tb_date_time_field_editor;
   import dtfe_pkg::*;

   // Clock values carried by one event word, and the edited view in one result word.
   typedef struct packed {
      logic [11:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
   } stamp_type;

   typedef struct packed {
      stamp_type  stamp;
      logic [2:0] field;
   } view_type;

   // Watchdog limit, well above what the slowest legal run needs.
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int REPORT_LIMIT  = 40;

   logic        clock;
   logic        reset         = 1'b1;
   logic        req_valid     = 1'b0;
   logic        req_stall;
   logic [2:0]  req_kind      = KIND_NEXT;
   logic [11:0] req_in_year   = '0;
   logic [3:0]  req_in_month  = '0;
   logic [4:0]  req_in_day    = '0;
   logic [4:0]  req_in_hour   = '0;
   logic [5:0]  req_in_minute = '0;
   logic [5:0]  req_in_second = '0;
   logic        rsp_valid;
   logic        rsp_stall     = 1'b0;
   logic [11:0] rsp_out_year;
   logic [3:0]  rsp_out_month;
   logic [4:0]  rsp_out_day;
   logic [4:0]  rsp_out_hour;
   logic [5:0]  rsp_out_minute;
   logic [5:0]  rsp_out_second;
   logic [2:0]  rsp_out_field;

   date_time_field_editor dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_kind       (req_kind),
      .req_in_year    (req_in_year),
      .req_in_month   (req_in_month),
      .req_in_day     (req_in_day),
      .req_in_hour    (req_in_hour),
      .req_in_minute  (req_in_minute),
      .req_in_second  (req_in_second),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_year   (rsp_out_year),
      .rsp_out_month  (rsp_out_month),
      .rsp_out_day    (rsp_out_day),
      .rsp_out_hour   (rsp_out_hour),
      .rsp_out_minute (rsp_out_minute),
      .rsp_out_second (rsp_out_second),
      .rsp_out_field  (rsp_out_field)
   );

   // Shadow copy of the editor state, advanced once per accepted event word.
   stamp_type  shadow;
   logic [2:0] shadow_field;
   logic       shadow_loaded;

   // Edited views still owed by the block, oldest first.
   view_type   expected_views[$];

   int         errors      = 0;
   int         cycle_count = 0;
   int         stall_hold  = 0;
   // When low, both sides run without gaps or stalls.
   logic       idle_on     = 1'b1;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Gregorian leap rule, written out directly with remainders.
   function automatic bit is_leap(input logic [11:0] y);
      int yi;
      yi = y;
      return (yi % 4 == 0) && ((yi % 100 != 0) || (yi % 400 == 0));
   endfunction

   // Month length; a month outside 1 to 12 is treated as 31 days long.
   function automatic int days_in_month(input logic [11:0] y, input logic [3:0] m);
      int days;
      case (m)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: days = 31;
         4'd4, 4'd6, 4'd9, 4'd11:                     days = 30;
         4'd2:                                        days = is_leap(y) ? 29 : 28;
         default:                                     days = 31;
      endcase
      return days;
   endfunction

   // Apply one event to the shadow state and queue the view it must produce.
   task automatic advance_editor(input logic [2:0] kind, input stamp_type clk_val);
      int  v;
      int  md;
      bit  up;
      up = (kind == KIND_UP);
      case (kind)
         KIND_NEXT: begin
            v = (int'(shadow_field) + 1) % 6;
            shadow_field = v[2:0];
         end
         KIND_UP, KIND_DOWN: begin
            case (shadow_field)
               SEL_YEAR: begin
                  // The year saturates rather than wraps.
                  if (up && shadow.year < YEAR_MAX) begin
                     shadow.year = shadow.year + 12'd1;
                  end else if (!up && shadow.year > YEAR_MIN) begin
                     shadow.year = shadow.year - 12'd1;
                  end
               end
               SEL_MONTH: begin
                  v = (up ? int'(shadow.month) + 12 : int'(shadow.month) + 10) % 12 + 1;
                  shadow.month = v[3:0];
               end
               SEL_DAY: begin
                  // The day wraps on day - 1 within the current month length.
                  md = days_in_month(shadow.year, shadow.month);
                  v  = (up ? int'(shadow.day) + md : int'(shadow.day) + md - 2) % md + 1;
                  shadow.day = v[4:0];
               end
               SEL_HOUR: begin
                  v = (up ? int'(shadow.hour) + 25 : int'(shadow.hour) + 23) % 24;
                  shadow.hour = v[4:0];
               end
               SEL_MINUTE: begin
                  v = (up ? int'(shadow.minute) + 61 : int'(shadow.minute) + 59) % 60;
                  shadow.minute = v[5:0];
               end
               SEL_SECOND: begin
                  v = (up ? int'(shadow.second) + 61 : int'(shadow.second) + 59) % 60;
                  shadow.second = v[5:0];
               end
               default: ;
            endcase
            // Every step ends by pulling the day down to the month length.
            md = days_in_month(shadow.year, shadow.month);
            if (int'(shadow.day) > md) begin
               shadow.day = md[4:0];
            end
         end
         KIND_UPDATE: begin
            // A clock update only takes effect until the first load.
            if (!shadow_loaded) begin
               shadow        = clk_val;
               shadow_loaded = 1'b1;
            end
         end
         KIND_SYNC: begin
            shadow        = clk_val;
            shadow_loaded = 1'b1;
         end
         default: ;
      endcase
      expected_views.push_back('{stamp: shadow, field: shadow_field});
   endtask

   // Idle length: mostly short, sometimes medium, rarely long.
   function automatic int draw_idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) begin
         return $urandom_range(1, 3);
      end else if (r < 94) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 60);
   endfunction

   function automatic stamp_type make_stamp(input int y, input int mo, input int d,
                                            input int h, input int mi, input int s);
      stamp_type t;
      t.year   = y[11:0];
      t.month  = mo[3:0];
      t.day    = d[4:0];
      t.hour   = h[4:0];
      t.minute = mi[5:0];
      t.second = s[5:0];
      return t;
   endfunction

   // Random clock values: either in the calendar ranges, with February ends
   // favored, or raw values over the full port widths.
   function automatic stamp_type random_stamp(input bit raw);
      stamp_type   t;
      logic [63:0] raw_bits;
      if (raw) begin
         raw_bits = {$urandom, $urandom};
         t = raw_bits[$bits(stamp_type)-1:0];
      end else begin
         t = make_stamp($urandom_range(2000, 2099), $urandom_range(1, 12),
                        $urandom_range(1, 31), $urandom_range(0, 23),
                        $urandom_range(0, 59), $urandom_range(0, 59));
         if ($urandom_range(0, 3) == 0) begin
            t.month = 4'd2;
            t.day   = 5'($urandom_range(27, 29));
         end
      end
      return t;
   endfunction

   // Send one event word. The valid stays high across back-to-back words and
   // is lowered only when a gap is taken, so it gets one assignment per step.
   task automatic send_event(input logic [2:0] kind, input stamp_type clk_val);
      int gap;
      gap = 0;
      if (idle_on && $urandom_range(0, 99) < 35) begin
         gap = draw_idle_len();
      end
      if (gap != 0) begin
         req_valid <= 1'b0;
         req_kind  <= 3'($urandom);
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_kind      <= kind;
      req_in_year   <= clk_val.year;
      req_in_month  <= clk_val.month;
      req_in_day    <= clk_val.day;
      req_in_hour   <= clk_val.hour;
      req_in_minute <= clk_val.minute;
      req_in_second <= clk_val.second;
      // The word is taken at the first edge at which stall is low.
      do begin
         @(posedge clock);
      end while (req_stall);
      advance_editor(kind, clk_val);
   endtask

   // Result side back pressure.
   always @(posedge clock) begin
      if (reset || !idle_on) begin
         rsp_stall  <= 1'b0;
         stall_hold <= 0;
      end else if (stall_hold != 0) begin
         rsp_stall  <= 1'b1;
         stall_hold <= stall_hold - 1;
      end else if ($urandom_range(0, 99) < 20) begin
         rsp_stall  <= 1'b1;
         stall_hold <= draw_idle_len() - 1;
      end else begin
         rsp_stall  <= 1'b0;
      end
   end

   function automatic void check_field(input string name, input int want_v, input int got_v);
      if (want_v != got_v) begin
         errors++;
         if (errors <= REPORT_LIMIT) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want_v, got_v);
         end
      end
   endfunction

   // Compare every accepted result word against the oldest owed view.
   always @(posedge clock) begin : check_views
      view_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_views.size() == 0) begin
            errors++;
            if (errors <= REPORT_LIMIT) begin
               $display("%0t: result word with none expected, got %0d-%0d-%0d field %0d",
                        $time, rsp_out_year, rsp_out_month, rsp_out_day, rsp_out_field);
            end
         end else begin
            want = expected_views.pop_front();
            check_field("year",   want.stamp.year,   rsp_out_year);
            check_field("month",  want.stamp.month,  rsp_out_month);
            check_field("day",    want.stamp.day,    rsp_out_day);
            check_field("hour",   want.stamp.hour,   rsp_out_hour);
            check_field("minute", want.stamp.minute, rsp_out_minute);
            check_field("second", want.stamp.second, rsp_out_second);
            check_field("field",  want.field,        rsp_out_field);
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // An unused kind leaves the state alone, so it shows the reset view.
   task automatic test_reset_view();
      send_event(3'd7, random_stamp(1'b1));
   endtask

   // The first clock update loads; later updates are ignored.
   task automatic test_update_once();
      send_event(KIND_UPDATE, make_stamp(2024, 2, 29, 12, 30, 45));
      send_event(KIND_UPDATE, make_stamp(2011, 7, 4, 1, 2, 3));
   endtask

   // Year field selected: leap day clamp after a year step, then both limits.
   task automatic test_year_saturation();
      send_event(KIND_UP, '0);
      send_event(KIND_SYNC, make_stamp(2099, 12, 31, 23, 59, 59));
      send_event(KIND_UP, '0);
      send_event(KIND_SYNC, make_stamp(2000, 1, 1, 0, 0, 0));
      send_event(KIND_DOWN, '0);
   endtask

   // Loads of all ones and all zeros, and year steps outside the range.
   task automatic test_raw_load();
      send_event(KIND_SYNC, '1);
      send_event(KIND_UP, '0);
      send_event(KIND_SYNC, '0);
      send_event(KIND_DOWN, '0);
      send_event(KIND_UP, '0);
   endtask

   // Month 0 steps up to 1 with day 0 left alone; month 15 wraps and clamps.
   task automatic test_month_wrap();
      send_event(KIND_NEXT, '0);
      send_event(KIND_UP, '0);
      send_event(KIND_DOWN, '0);
      send_event(KIND_SYNC, make_stamp(2023, 15, 31, 8, 8, 8));
      send_event(KIND_UP, '0);
   endtask

   // Day wraps in a century year that is not leap and in one that is.
   task automatic test_day_wrap_leap();
      send_event(KIND_NEXT, '0);
      send_event(KIND_SYNC, make_stamp(2100, 2, 28, 0, 0, 0));
      send_event(KIND_UP, '0);
      send_event(KIND_DOWN, '0);
      send_event(KIND_SYNC, make_stamp(2000, 2, 29, 0, 0, 0));
      send_event(KIND_UP, '0);
      send_event(KIND_DOWN, '0);
   endtask

   // Hour, minute and second wrap below zero, and the selection wraps to year.
   task automatic test_time_wrap();
      send_event(KIND_NEXT, '0);
      send_event(KIND_DOWN, '0);
      send_event(KIND_NEXT, '0);
      send_event(KIND_DOWN, '0);
      send_event(KIND_NEXT, '0);
      send_event(KIND_DOWN, '0);
      send_event(KIND_UP, '0);
      send_event(KIND_NEXT, '0);
   endtask

   // One random event: mostly field moves and steps, with loads mixed in.
   task automatic send_random_event();
      int r;
      r = $urandom_range(0, 99);
      if (r < 15) begin
         send_event(KIND_NEXT, random_stamp(1'b1));
      end else if (r < 50) begin
         send_event(KIND_UP, random_stamp(1'b1));
      end else if (r < 85) begin
         send_event(KIND_DOWN, random_stamp(1'b1));
      end else if (r < 92) begin
         send_event(KIND_SYNC, random_stamp(1'b0));
      end else if (r < 95) begin
         send_event(KIND_SYNC, random_stamp(1'b1));
      end else if (r < 98) begin
         send_event(KIND_UPDATE, random_stamp(1'($urandom_range(0, 1))));
      end else begin
         send_event(3'($urandom_range(5, 7)), random_stamp(1'b1));
      end
   endtask

   // A stretch with no gaps and no stalls on either side; the next test sets
   // its own idling.
   task automatic test_back_to_back();
      idle_on <= 1'b0;
      repeat (150) send_random_event();
   endtask

   // Long random run in blocks, most with idling and some without.
   task automatic test_random();
      repeat (17) begin
         idle_on <= ($urandom_range(0, 3) != 0);
         repeat (100) send_random_event();
      end
      idle_on <= 1'b1;
   endtask

   initial begin
      shadow        = make_stamp(2026, 1, 1, 0, 0, 0);
      shadow_field  = SEL_YEAR;
      shadow_loaded = 1'b0;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_view();
      test_update_once();
      test_year_saturation();
      test_raw_load();
      test_month_wrap();
      test_day_wrap_leap();
      test_time_wrap();
      test_back_to_back();
      test_random();

      req_valid <= 1'b0;
      while (expected_views.size() != 0) begin
         @(posedge clock);
      end
      // Let any stray word show up before the verdict.
      repeat (8) @(posedge clock);

      if (errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

>>> files.f
rtl/dtfe_pkg.sv
rtl/date_time_field_editor.sv
tb/tb_date_time_field_editor.sv
